>>> rtl/core/crsa_pkg.sv
// shared types, codes and defaults for the contiguous ring string allocator
`default_nettype none

package crsa_pkg;

  // default ring size in bytes
  localparam int DEF_BUFFER_BYTES = 256;

  // fixed field widths
  localparam int KIND_W    = 3;
  localparam int LEN_W     = 8;
  localparam int OFF_W     = 8;
  localparam int CNT_W     = 8;
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 1;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_FIT      = 3'd0,
    KIND_PUSH     = 3'd1,
    KIND_DROP_OLD = 3'd2,
    KIND_DROP_NEW = 3'd3,
    KIND_CLEAR    = 3'd4
  } kind_e;

  // result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming request word
    logic commit;   // update pointers and load the result register
  } ring_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/crsa_ctrl.sv
// request sequencer and output valid tracking
`default_nettype none

module crsa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output crsa_pkg::ring_cmd_t    cmd_o
);
  import crsa_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.capture = s_axis_tvalid;
      end
      ST_EXEC: begin
        cmd_o.commit = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // result register holds until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_commit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed result not presented");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !cmd_o.commit)
    else $error("pending result overwritten");
  a_capture_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == ST_EXEC))
    else $error("captured request not executed");
`endif

endmodule

`default_nettype wire

>>> rtl/core/crsa_datapath.sv
// pointer registers, fit and drop evaluation, result register
`default_nettype none

module crsa_datapath #(
  parameter int BUFFER_BYTES = crsa_pkg::DEF_BUFFER_BYTES
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire crsa_pkg::ring_cmd_t               cmd_i,
  input  wire logic [crsa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  wire logic [crsa_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic      [crsa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic      [crsa_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
  import crsa_pkg::*;

  localparam int PTR_W = $clog2(BUFFER_BYTES) + 1;
  localparam int CW    = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 2;
  localparam logic [CW-1:0] BUF_SIZE = CW'(BUFFER_BYTES);

  // request register
  kind_e            kind_q;
  logic [LEN_W-1:0] len_q;
  logic [OFF_W-1:0] at_q;

  // ring pointers
  logic [PTR_W-1:0] os_q, os_d, we_q, we_d, re_q, re_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // result register
  logic             status_q, status_d;
  logic [7:0]       place_q, place_d, fitlen_q, fitlen_d;
  logic             fits_q, fits_d, empty_q, empty_d;
  logic [CNT_W-1:0] entries_q;

  // widened operands
  logic [CW-1:0] os_w, we_w, re_w, len_w, len1_w, at_w;
  assign os_w   = CW'(os_q);
  assign we_w   = CW'(we_q);
  assign re_w   = CW'(re_q);
  assign len_w  = CW'(len_q);
  assign len1_w = len_w + CW'(1);
  assign at_w   = CW'(at_q);

  logic ring_empty;
  assign ring_empty = (os_q == we_q) && (cnt_q == '0);

  // fit search
  logic [CW-1:0] gap, low_raw, low, high_room, high_raw, high;
  logic [CW-1:0] fit_place, fit_len;
  logic          fit_ok, fit_full;

  assign gap       = os_w - CW'(1) - we_w;
  assign low_raw   = (os_w < len1_w) ? os_w : len1_w;
  assign low       = (low_raw != '0) ? low_raw - CW'(1) : '0;
  assign high_room = BUF_SIZE - we_w;
  assign high_raw  = (we_w <= BUF_SIZE) ? ((high_room < len1_w) ? high_room : len1_w) : '0;
  assign high      = (high_raw != '0) ? high_raw - CW'(1) : '0;

  always_comb begin
    fit_ok    = 1'b1;
    fit_place = '0;
    fit_len   = '0;
    if (len_q == '0 || we_w > re_w) begin
      fit_ok = 1'b0;
    end else if (ring_empty) begin
      if (len_w >= BUF_SIZE) begin
        fit_ok = 1'b0;
      end else begin
        fit_place = os_w;
        fit_len   = len_w;
      end
    end else if (os_w > we_w) begin
      fit_place = we_w;
      fit_len   = (gap < len_w) ? gap : len_w;
    end else if (os_w < we_w) begin
      if (high == len_w || high >= low) begin
        fit_place = we_w;
        fit_len   = high;
      end else begin
        fit_place = '0;
        fit_len   = low;
      end
    end
  end

  assign fit_full = fit_ok && (fit_len == len_w);

  // push end
  logic [CW-1:0] push_end;
  assign push_end = fit_place + len1_w;

  // drop oldest
  logic [CW-1:0] old_next;
  logic          old_pre_ok;
  assign old_next   = os_w + len1_w;
  assign old_pre_ok = (at_w == os_w) && !ring_empty && (cnt_q != '0) && (os_w < re_w)
                      && (we_w <= re_w) && (len_q != '0) && (old_next <= re_w);

  // drop newest
  logic [CW-1:0]    new_top;
  logic             new_ok;
  logic [CNT_W-1:0] cnt_dec;
  logic [PTR_W-1:0] dn_we, dn_re;
  logic             dn_wrap, dn_clear;
  assign new_top  = at_w + len1_w;
  assign cnt_dec  = cnt_q - CNT_W'(1);
  assign new_ok   = (len_q != '0) && !ring_empty && (cnt_q != '0) && (new_top == we_w)
                    && (os_w < re_w) && (we_w <= re_w);
  // entry at offset zero below the oldest: write end returns to the upper region end
  assign dn_wrap  = (at_q == '0) && !((os_q == '0) && (cnt_dec == '0));
  assign dn_we    = dn_wrap ? re_q : PTR_W'(at_w);
  assign dn_re    = (!dn_wrap && (os_w <= at_w)) ? PTR_W'(at_w) : re_q;
  assign dn_clear = (os_q == dn_we) && (cnt_dec == '0);

  always_comb begin
    os_d     = os_q;
    we_d     = we_q;
    re_d     = re_q;
    cnt_d    = cnt_q;
    status_d = STATUS_ERR;
    place_d  = '0;
    fitlen_d = '0;
    fits_d   = 1'b0;
    case (kind_q)
      KIND_FIT: begin
        if (fit_ok) begin
          status_d = STATUS_OK;
          place_d  = fit_place[7:0];
          fitlen_d = fit_len[7:0];
          fits_d   = fit_full;
        end
      end
      KIND_PUSH: begin
        if (fit_full && cnt_q != {CNT_W{1'b1}}) begin
          status_d = STATUS_OK;
          place_d  = fit_place[7:0];
          fitlen_d = fit_len[7:0];
          fits_d   = 1'b1;
          cnt_d    = cnt_q + CNT_W'(1);
          we_d     = PTR_W'(push_end);
          if (push_end > re_w) re_d = PTR_W'(push_end);
        end
      end
      KIND_DROP_OLD: begin
        if (old_pre_ok) begin
          if (old_next < re_w) begin
            status_d = STATUS_OK;
            os_d     = PTR_W'(old_next);
            cnt_d    = cnt_dec;
          end else if (!(we_w == re_w && cnt_q != CNT_W'(1))) begin
            // upper region exhausted: oldest moves to the low region
            status_d = STATUS_OK;
            cnt_d    = cnt_dec;
            os_d     = '0;
            if (we_w == re_w) begin
              we_d = '0;
              re_d = '0;
            end else begin
              re_d = we_q;
            end
          end
        end
      end
      KIND_DROP_NEW: begin
        if (new_ok) begin
          status_d = STATUS_OK;
          cnt_d    = cnt_dec;
          if (dn_clear) begin
            os_d = '0;
            we_d = '0;
            re_d = '0;
          end else begin
            we_d = dn_we;
            re_d = dn_re;
          end
        end
      end
      KIND_CLEAR: begin
        status_d = STATUS_OK;
        os_d     = '0;
        we_d     = '0;
        re_d     = '0;
        cnt_d    = '0;
      end
      default: begin
        status_d = STATUS_ERR;
      end
    endcase
  end

  assign empty_d = (os_d == we_d) && (cnt_d == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      os_q  <= '0;
      we_q  <= '0;
      re_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.commit) begin
      os_q  <= os_d;
      we_q  <= we_d;
      re_q  <= re_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_e'(s_axis_tuser);
      len_q  <= s_axis_tdata[LEN_W-1:0];
      at_q   <= s_axis_tdata[LEN_W+OFF_W-1:LEN_W];
    end
    if (cmd_i.commit) begin
      status_q  <= status_d;
      place_q   <= place_d;
      fitlen_q  <= fitlen_d;
      fits_q    <= fits_d;
      entries_q <= cnt_d;
      empty_q   <= empty_d;
    end
  end

  assign m_axis_tuser = status_q;
  assign m_axis_tdata = {6'd0, empty_q, entries_q, fits_q, fitlen_q, place_q};

`ifndef NO_ASSERTIONS
  a_error_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && status_d == STATUS_ERR) |=>
      (os_q == $past(os_q) && we_q == $past(we_q) && re_q == $past(re_q)
       && cnt_q == $past(cnt_q)))
    else $error("rejected request changed the ring state");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CNT_W'(1)
                      || cnt_q == $past(cnt_q) - CNT_W'(1) || cnt_q == '0))
    else $error("entry count moved by more than one");
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> ($stable(os_q) && $stable(we_q) && $stable(re_q) && $stable(cnt_q)))
    else $error("ring state changed without a commit");
`endif

endmodule

`default_nettype wire

>>> rtl/core/contiguous_ring_string_allocator.sv
// top level of the contiguous ring string allocator
// an accepted request word is latched in the request register; its result is then loaded into the result register
// a new request is accepted only after the previous one has been committed to the result register
// a finished result waits in the output register while the next request is taken
// reset (rst_ni low, asynchronous) empties the ring: all pointers and the count go to zero
// no clearing pass is needed after reset; the first request can be taken at once
`default_nettype none

module contiguous_ring_string_allocator #(
  parameter int BUFFER_BYTES = crsa_pkg::DEF_BUFFER_BYTES  // ring size in bytes, 4 to 256
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request side
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [crsa_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // length[7:0], offset[15:8]
  input  wire logic [crsa_pkg::IN_USER_W-1:0]    s_axis_tuser,  // kind[2:0]
  // result side
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [crsa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // place[7:0], fit_length[15:8],
                                                                // fits[16], entries[24:17],
                                                                // is_empty[25], zero[31:26]
  output logic      [crsa_pkg::OUT_USER_W-1:0]   m_axis_tuser   // status[0]
);
  import crsa_pkg::*;

  // command word from the sequencer to the pointer datapath
  ring_cmd_t cmd;

  // sequencer: takes a request word in idle, commits it once the result register is free
  crsa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  // datapath: pointer registers, fit search, drop checks and the result register
  crsa_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

`default_nettype wire
